// ===== rtl/tfr_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tfr_pkg
// shared constants, register indexes and controller/datapath interface types
// for the token find-and-replace block
// ----------------------------------------------------------------------------
package tfr_pkg;

    localparam int TOKEN_MAX_DEF   = 32;
    localparam int PATTERN_MAX_DEF = 16;
    localparam int REPLACE_MAX     = 16;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 64;
    localparam int LEN_W      = 5;

    localparam logic [7:0] DASH_CHAR    = 8'd45;
    localparam logic [7:0] NEWLINE_CHAR = 8'd10;
    localparam logic [7:0] CHAR_UPPER_A = 8'h41;
    localparam logic [7:0] CHAR_UPPER_Z = 8'h5a;
    localparam logic [7:0] CHAR_LOWER_A = 8'h61;
    localparam logic [7:0] CHAR_LOWER_Z = 8'h7a;
    localparam logic [7:0] CHAR_DIGIT_0 = 8'h30;
    localparam logic [7:0] CHAR_DIGIT_9 = 8'h39;
    localparam logic [7:0] CASE_OFFSET  = 8'd32;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PATTERN_LOW  = 3'd0,
        CFG_PATTERN_HIGH = 3'd1,
        CFG_PATTERN_LEN  = 3'd2,
        CFG_REPLACE_LOW  = 3'd3,
        CFG_REPLACE_HIGH = 3'd4,
        CFG_REPLACE_LEN  = 3'd5,
        CFG_CASE_IGNORE  = 3'd6
    } cfg_idx_t;

    typedef struct packed {
        logic store;
        logic clear_count;
        logic search_init;
        logic k_inc;
        logic k_zero;
        logic k_post;
        logic pos_next;
        logic rd_search;
        logic rd_k;
        logic load_tok;
        logic load_rep;
        logic load_nl;
    } tfr_cmd_t;

    typedef struct packed {
        logic is_token;
        logic count_zero;
        logic plen_gt_count;
        logic k_eq_plen;
        logic cmp_eq;
        logic pos_last;
        logic k_eq_pos;
        logic k_eq_rlen;
        logic k_eq_count;
        logic out_free;
    } tfr_status_t;

    function automatic logic is_token_byte(input logic [7:0] c);
        return ((c >= CHAR_LOWER_A) && (c <= CHAR_LOWER_Z)) ||
               ((c >= CHAR_UPPER_A) && (c <= CHAR_UPPER_Z)) ||
               ((c >= CHAR_DIGIT_0) && (c <= CHAR_DIGIT_9)) ||
               (c == DASH_CHAR);
    endfunction

    function automatic logic [7:0] fold_case(input logic [7:0] c, input logic ci);
        if (ci && (c >= CHAR_UPPER_A) && (c <= CHAR_UPPER_Z))
            return c + CASE_OFFSET;
        return c;
    endfunction

endpackage

// ===== rtl/tfr_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tfr_ctrl
// sequencer: token collection, pattern search and emission of the rewritten
// token, driving the datapath by command and reading back status
// ----------------------------------------------------------------------------
module tfr_ctrl
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 text_valid,
    output logic                 text_stall,
    input  tfr_pkg::tfr_status_t status,
    output tfr_pkg::tfr_cmd_t    cmd
);
    import tfr_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE,
        S_INIT,
        S_SRD,
        S_SCMP,
        S_PRE,
        S_PRE_W,
        S_REP,
        S_POST,
        S_POST_W,
        S_NL
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   accept;

    assign text_stall = (state_reg != S_IDLE);
    assign accept     = text_valid && !text_stall;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    if (status.is_token)
                        cmd.store = 1'b1;
                    else if (!status.count_zero)
                    begin
                        cmd.search_init = 1'b1;
                        state_next      = S_INIT;
                    end
                end
            end
            S_INIT:
            begin
                if (status.plen_gt_count)
                begin
                    cmd.clear_count = 1'b1;
                    state_next      = S_IDLE;
                end
                else
                    state_next = S_SRD;
            end
            S_SRD:
            begin
                if (status.k_eq_plen)
                begin
                    cmd.k_zero = 1'b1;
                    state_next = S_PRE;
                end
                else
                begin
                    cmd.rd_search = 1'b1;
                    state_next    = S_SCMP;
                end
            end
            S_SCMP:
            begin
                if (status.cmp_eq)
                begin
                    cmd.k_inc  = 1'b1;
                    state_next = S_SRD;
                end
                else if (status.pos_last)
                begin
                    cmd.clear_count = 1'b1;
                    state_next      = S_IDLE;
                end
                else
                begin
                    cmd.pos_next = 1'b1;
                    state_next   = S_SRD;
                end
            end
            S_PRE:
            begin
                if (status.k_eq_pos)
                begin
                    cmd.k_zero = 1'b1;
                    state_next = S_REP;
                end
                else
                begin
                    cmd.rd_k   = 1'b1;
                    state_next = S_PRE_W;
                end
            end
            S_PRE_W:
            begin
                if (status.out_free)
                begin
                    cmd.load_tok = 1'b1;
                    cmd.k_inc    = 1'b1;
                    state_next   = S_PRE;
                end
            end
            S_REP:
            begin
                if (status.k_eq_rlen)
                begin
                    cmd.k_post = 1'b1;
                    state_next = S_POST;
                end
                else if (status.out_free)
                begin
                    cmd.load_rep = 1'b1;
                    cmd.k_inc    = 1'b1;
                end
            end
            S_POST:
            begin
                if (status.k_eq_count)
                    state_next = S_NL;
                else
                begin
                    cmd.rd_k   = 1'b1;
                    state_next = S_POST_W;
                end
            end
            S_POST_W:
            begin
                if (status.out_free)
                begin
                    cmd.load_tok = 1'b1;
                    cmd.k_inc    = 1'b1;
                    state_next   = S_POST;
                end
            end
            S_NL:
            begin
                if (status.out_free)
                begin
                    cmd.load_nl     = 1'b1;
                    cmd.clear_count = 1'b1;
                    state_next      = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

endmodule

// ===== rtl/tfr_dp.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tfr_dp
// datapath: configuration registers, token memory, search and emission
// counters, folded byte compare and the result output register
// ----------------------------------------------------------------------------
module tfr_dp
#(
    parameter int TOKEN_MAX   = tfr_pkg::TOKEN_MAX_DEF,
    parameter int PATTERN_MAX = tfr_pkg::PATTERN_MAX_DEF
)
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_valid,
    input  logic [tfr_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [tfr_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  logic [7:0]                      char_in,
    output logic                            result_valid,
    input  logic                            result_stall,
    output logic [7:0]                      char_out,
    output logic                            last,
    input  tfr_pkg::tfr_cmd_t               cmd,
    output tfr_pkg::tfr_status_t            status
);
    import tfr_pkg::*;

    localparam int CW   = $clog2(TOKEN_MAX + 1);
    localparam int AW   = (TOKEN_MAX > 1) ? $clog2(TOKEN_MAX) : 1;
    localparam int KMAX = (TOKEN_MAX > REPLACE_MAX) ? TOKEN_MAX : REPLACE_MAX;
    localparam int IW   = $clog2(KMAX + 1);
    localparam int SW   = IW + 1;

    logic [CFG_DATA_W-1:0] pat_low_reg;
    logic [CFG_DATA_W-1:0] pat_high_reg;
    logic [LEN_W-1:0]      pat_len_reg;
    logic [CFG_DATA_W-1:0] rep_low_reg;
    logic [CFG_DATA_W-1:0] rep_high_reg;
    logic [LEN_W-1:0]      rep_len_reg;
    logic                  case_ignore_reg;

    logic [7:0]    token_mem [TOKEN_MAX];
    logic [7:0]    rd_data_reg;
    logic [CW-1:0] count_reg;
    logic [CW-1:0] pos_reg;
    logic [IW-1:0] k_reg;

    logic          out_valid_reg;
    logic [7:0]    char_out_reg;
    logic          last_reg;

    logic [LEN_W-1:0]          plen;
    logic [LEN_W-1:0]          rlen;
    logic [2*CFG_DATA_W-1:0]   pat_word;
    logic [2*CFG_DATA_W-1:0]   rep_word;
    logic [7:0]                pat_byte;
    logic [7:0]                rep_byte;
    logic [SW-1:0]             search_sum;
    logic [AW-1:0]             rd_addr;
    logic                      rd_en;
    logic                      room;

    assign plen = (pat_len_reg > LEN_W'(PATTERN_MAX)) ? LEN_W'(PATTERN_MAX) : pat_len_reg;
    assign rlen = (rep_len_reg > LEN_W'(REPLACE_MAX)) ? LEN_W'(REPLACE_MAX) : rep_len_reg;

    assign pat_word = {pat_high_reg, pat_low_reg};
    assign rep_word = {rep_high_reg, rep_low_reg};
    assign pat_byte = pat_word[k_reg[3:0]*8 +: 8];
    assign rep_byte = rep_word[k_reg[3:0]*8 +: 8];

    assign search_sum = SW'(pos_reg) + SW'(k_reg);
    assign rd_addr    = cmd.rd_search ? search_sum[AW-1:0] : k_reg[AW-1:0];
    assign rd_en      = cmd.rd_search || cmd.rd_k;
    assign room       = (count_reg != CW'(TOKEN_MAX));

    assign status.is_token      = is_token_byte(char_in);
    assign status.count_zero    = (count_reg == '0);
    assign status.plen_gt_count = (SW'(plen) > SW'(count_reg));
    assign status.k_eq_plen     = (SW'(k_reg) == SW'(plen));
    assign status.cmp_eq        = (fold_case(rd_data_reg, case_ignore_reg) ==
                                   fold_case(pat_byte, case_ignore_reg));
    assign status.pos_last      = ((SW'(pos_reg) + SW'(1) + SW'(plen)) > SW'(count_reg));
    assign status.k_eq_pos      = (k_reg == IW'(pos_reg));
    assign status.k_eq_rlen     = (SW'(k_reg) == SW'(rlen));
    assign status.k_eq_count    = (k_reg == IW'(count_reg));
    assign status.out_free      = !out_valid_reg || !result_stall;

    assign result_valid = out_valid_reg;
    assign char_out     = char_out_reg;
    assign last         = last_reg;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pat_low_reg     <= '0;
            pat_high_reg    <= '0;
            pat_len_reg     <= '0;
            rep_low_reg     <= '0;
            rep_high_reg    <= '0;
            rep_len_reg     <= '0;
            case_ignore_reg <= 1'b0;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_idx_t'(cfg_index))
                CFG_PATTERN_LOW:  pat_low_reg     <= cfg_data;
                CFG_PATTERN_HIGH: pat_high_reg    <= cfg_data;
                CFG_PATTERN_LEN:  pat_len_reg     <= cfg_data[LEN_W-1:0];
                CFG_REPLACE_LOW:  rep_low_reg     <= cfg_data;
                CFG_REPLACE_HIGH: rep_high_reg    <= cfg_data;
                CFG_REPLACE_LEN:  rep_len_reg     <= cfg_data[LEN_W-1:0];
                CFG_CASE_IGNORE:  case_ignore_reg <= cfg_data[0];
                default:          ;
            endcase
        end
    end

    // token memory, one write and one registered read port
    always_ff @(posedge clk)
    begin
        if (cmd.store && room)
            token_mem[count_reg[AW-1:0]] <= char_in;
        if (rd_en)
            rd_data_reg <= token_mem[rd_addr];
    end

    // token fill count and search/emission counters
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            pos_reg   <= '0;
            k_reg     <= '0;
        end
        else
        begin
            if (cmd.clear_count)
                count_reg <= '0;
            else if (cmd.store && room)
                count_reg <= count_reg + CW'(1);

            if (cmd.search_init)
                pos_reg <= '0;
            else if (cmd.pos_next)
                pos_reg <= pos_reg + CW'(1);

            priority if (cmd.search_init || cmd.k_zero || cmd.pos_next)
                k_reg <= '0;
            else if (cmd.k_post)
                k_reg <= IW'(SW'(pos_reg) + SW'(plen));
            else if (cmd.k_inc)
                k_reg <= k_reg + IW'(1);
            else
                k_reg <= k_reg;
        end
    end

    // result output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.load_tok || cmd.load_rep || cmd.load_nl)
            out_valid_reg <= 1'b1;
        else if (!result_stall)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        priority if (cmd.load_tok)
        begin
            char_out_reg <= rd_data_reg;
            last_reg     <= 1'b0;
        end
        else if (cmd.load_rep)
        begin
            char_out_reg <= rep_byte;
            last_reg     <= 1'b0;
        end
        else if (cmd.load_nl)
        begin
            char_out_reg <= NEWLINE_CHAR;
            last_reg     <= 1'b1;
        end
        else
        begin
            char_out_reg <= char_out_reg;
            last_reg     <= last_reg;
        end
    end

endmodule

// ===== rtl/token_find_replace.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// token_find_replace
// token-wise find and replace on a byte stream
//
//   channel   signals                                   beat
//   text      text_valid, text_stall, char_in           one input byte
//   result    result_valid, result_stall, char_out,     one output byte
//             last
//   config    cfg_valid, cfg_ready, cfg_index, cfg_data one register write
//
// a token byte is accepted without a stall; a delimiter ending a token of n
// bytes with pattern length p starts a search over up to n-p+1 positions,
// comparing one byte at a time through the single read port of the token memory
// on a match, emission sends the token bytes before it, the replacement bytes,
// the token bytes after it and the newline, and waits while the result side
// holds stall
// text_stall is high from a closing delimiter until the newline is loaded or the search ends without a match
// reset clears the configuration registers, the token count, the counters and the output valid; no clearing pass
// ----------------------------------------------------------------------------
module token_find_replace
#(
    parameter int TOKEN_MAX   = tfr_pkg::TOKEN_MAX_DEF,
    parameter int PATTERN_MAX = tfr_pkg::PATTERN_MAX_DEF
)
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            text_valid,
    output logic                            text_stall,
    input  logic [7:0]                      char_in,
    output logic                            result_valid,
    input  logic                            result_stall,
    output logic [7:0]                      char_out,
    output logic                            last,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [tfr_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [tfr_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import tfr_pkg::*;

    tfr_cmd_t    cmd;
    tfr_status_t status;

    assign cfg_ready = 1'b1;

    tfr_ctrl u_ctrl
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .text_valid (text_valid),
        .text_stall (text_stall),
        .status     (status),
        .cmd        (cmd)
    );

    tfr_dp
    #(
        .TOKEN_MAX   (TOKEN_MAX),
        .PATTERN_MAX (PATTERN_MAX)
    )
    u_dp
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_valid    (cfg_valid && cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .char_in      (char_in),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .char_out     (char_out),
        .last         (last),
        .cmd          (cmd),
        .status       (status)
    );

endmodule

// ===== rtl/tfr_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tfr_checker
// port-level checks on the token find-and-replace block, bound to the top
// ----------------------------------------------------------------------------
module tfr_checker
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       text_valid,
    input  logic       text_stall,
    input  logic [7:0] char_in,
    input  logic       result_valid,
    input  logic       result_stall,
    input  logic [7:0] char_out,
    input  logic       last
);
    logic token_beat;

    assign token_beat = text_valid && !text_stall &&
                        (((char_in >= 8'h61) && (char_in <= 8'h7a)) ||
                         ((char_in >= 8'h41) && (char_in <= 8'h5a)) ||
                         ((char_in >= 8'h30) && (char_in <= 8'h39)) ||
                         (char_in == 8'd45));

    // stalled result beat holds
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> result_valid && $stable(char_out) && $stable(last))
    else $error("result beat changed while stalled");

    a_last_newline: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && last |-> char_out == 8'd10)
    else $error("last beat is not a newline");

    a_token_no_stall: assert property (@(posedge clk) disable iff (!rst_n)
        token_beat |=> !text_stall)
    else $error("token byte caused a stall");

    a_busy_until_newline: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !last && !result_stall |=> result_valid || text_stall)
    else $error("token ended without closing newline");

endmodule

bind token_find_replace tfr_checker u_tfr_checker
(
    .clk          (clk),
    .rst_n        (rst_n),
    .text_valid   (text_valid),
    .text_stall   (text_stall),
    .char_in      (char_in),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .char_out     (char_out),
    .last         (last)
);

// ===== tb/sv/token_find_replace_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// token_find_replace_test
// self-checking bench for the token find-and-replace block
//
// feeds text made mostly of words that carry the current pattern, mixed with
// noise bytes, under a series of rule sets written through the config port.
// a scoreboard class keeps its own copy of the rules and of the word being
// collected, rebuilds every rewritten word and compares each output beat
// ----------------------------------------------------------------------------
module token_find_replace_test;
    import tfr_pkg::*;

    localparam int WORD_MAX     = TOKEN_MAX_DEF;
    localparam int DRAIN_CYCLES = 700;
    localparam int HOLD_CYCLES  = 400;
    localparam int QUIET_LIMIT  = 6000;
    localparam int PHASE_ITEMS  = 32;
    localparam int PHASES       = 8;
    localparam logic [CFG_IDX_W-1:0] CFG_BAD_INDEX = 3'd7;

    typedef struct {
        logic [7:0] ch;
        logic       nl;
    } out_beat_t;

    function automatic bit is_word_byte(input logic [7:0] c);
        return ((c >= CHAR_LOWER_A) && (c <= CHAR_LOWER_Z)) ||
               ((c >= CHAR_UPPER_A) && (c <= CHAR_UPPER_Z)) ||
               ((c >= CHAR_DIGIT_0) && (c <= CHAR_DIGIT_9)) ||
               (c == DASH_CHAR);
    endfunction

    class rewrite_scoreboard;
        logic [63:0] pat_lo, pat_hi, rep_lo, rep_hi;
        logic [4:0]  pat_len, rep_len;
        logic        fold_on;
        logic [7:0]  word_buf[WORD_MAX];
        int          word_len;
        out_beat_t   rewrite_q[$];
        int          errors, beats_seen, words_closed, words_rewritten;

        function new();
            pat_lo = '0;
            pat_hi = '0;
            rep_lo = '0;
            rep_hi = '0;
            pat_len = '0;
            rep_len = '0;
            fold_on = 1'b0;
            word_len = 0;
            errors = 0;
            beats_seen = 0;
            words_closed = 0;
            words_rewritten = 0;
        endfunction

        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                CFG_PATTERN_LOW:  pat_lo = data;
                CFG_PATTERN_HIGH: pat_hi = data;
                CFG_PATTERN_LEN:  pat_len = data[4:0];
                CFG_REPLACE_LOW:  rep_lo = data;
                CFG_REPLACE_HIGH: rep_hi = data;
                CFG_REPLACE_LEN:  rep_len = data[4:0];
                CFG_CASE_IGNORE:  fold_on = data[0];
                default: ;
            endcase
        endfunction

        function logic [7:0] folded(logic [7:0] c);
            if (fold_on && (c >= CHAR_UPPER_A) && (c <= CHAR_UPPER_Z))
                return c + CASE_OFFSET;
            return c;
        endfunction

        function logic [7:0] rule_byte(logic [63:0] lo, logic [63:0] hi, int k);
            return (k < 8) ? lo[8*k +: 8] : hi[8*(k-8) +: 8];
        endfunction

        // returns 0 for a delimiter that closes nothing
        function bit note_byte(logic [7:0] b);
            int  p, r, at, s, k;
            bit  same;
            if (is_word_byte(b))
            begin
                if (word_len < WORD_MAX)
                begin
                    word_buf[word_len] = b;
                    word_len++;
                end
                return 1'b1;
            end
            if (word_len == 0)
                return 1'b0;
            p = (pat_len > PATTERN_MAX_DEF) ? PATTERN_MAX_DEF : int'(pat_len);
            r = (rep_len > REPLACE_MAX) ? REPLACE_MAX : int'(rep_len);
            at = -1;
            for (s = 0; (s + p <= word_len) && (at < 0); s++)
            begin
                same = 1'b1;
                for (k = 0; k < p; k++)
                    if (folded(word_buf[s + k]) != folded(rule_byte(pat_lo, pat_hi, k)))
                        same = 1'b0;
                if (same)
                    at = s;
            end
            words_closed++;
            if (at >= 0)
            begin
                words_rewritten++;
                for (k = 0; k < at; k++)
                    rewrite_q.push_back('{word_buf[k], 1'b0});
                for (k = 0; k < r; k++)
                    rewrite_q.push_back('{rule_byte(rep_lo, rep_hi, k), 1'b0});
                for (k = at + p; k < word_len; k++)
                    rewrite_q.push_back('{word_buf[k], 1'b0});
                rewrite_q.push_back('{NEWLINE_CHAR, 1'b1});
            end
            word_len = 0;
            return 1'b1;
        endfunction

        function void fail(string what);
            errors++;
            if (errors <= 10)
                $display("[%0t] mismatch: %s", $time, what);
        endfunction

        function void check_beat(logic [7:0] ch, logic nl);
            out_beat_t want;
            beats_seen++;
            if (rewrite_q.size() == 0)
            begin
                fail($sformatf("unexpected beat char_out=%02h last=%0b", ch, nl));
                return;
            end
            want = rewrite_q.pop_front();
            if (ch !== want.ch)
                fail($sformatf("char_out expected %02h got %02h", want.ch, ch));
            if (nl !== want.nl)
                fail($sformatf("last expected %0b got %0b (char %02h)", want.nl, nl, ch));
        endfunction

        function int pending();
            return rewrite_q.size();
        endfunction
    endclass

    logic                  clk;
    logic                  rst_n;
    logic                  text_valid;
    logic                  text_stall;
    logic [7:0]            char_in;
    logic                  result_valid;
    logic                  result_stall;
    logic [7:0]            char_out;
    logic                  last;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    rewrite_scoreboard sb;
    logic [7:0]        pat_text[16];
    logic [7:0]        rep_text[16];
    int                eff_plen;
    bit                fold_now;
    bit                calm;
    bit                hold_req;
    int                fed_items;
    int                rule_sets;

    token_find_replace DUT
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .text_valid   (text_valid),
        .text_stall   (text_stall),
        .char_in      (char_in),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .char_out     (char_out),
        .last         (last),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic logic [7:0] rand_word_byte();
        int r;
        r = $urandom_range(62);
        if (r < 26)
            return CHAR_LOWER_A + 8'(r);
        if (r < 52)
            return CHAR_UPPER_A + 8'(r - 26);
        if (r < 62)
            return CHAR_DIGIT_0 + 8'(r - 52);
        return DASH_CHAR;
    endfunction

    function automatic logic [7:0] rand_gap_byte();
        logic [7:0] b;
        b = 8'($urandom_range(255));
        while (is_word_byte(b))
            b = 8'($urandom_range(255));
        return b;
    endfunction

    task automatic send_byte(input logic [7:0] b);
        while (!calm && ($urandom_range(99) < 28))
        begin
            text_valid <= 1'b0;
            @(posedge clk);
        end
        text_valid <= 1'b1;
        char_in    <= b;
        @(posedge clk);
        while (text_stall)
            @(posedge clk);
        if (sb.note_byte(b))
            fed_items++;
    endtask

    task automatic send_text(input string s);
        int i;
        for (i = 0; i < s.len(); i++)
            send_byte(s[i]);
    endtask

    // word of random bytes, optionally carrying the pattern, with case flips under case ignore
    task automatic send_word(input int len, input bit plant);
        logic [7:0] word[$];
        logic [7:0] b;
        int         i, at;
        for (i = 0; i < len; i++)
            word.push_back(rand_word_byte());
        if (plant && (eff_plen > 0))
        begin
            at = $urandom_range(len);
            for (i = 0; i < eff_plen; i++)
            begin
                b = pat_text[i];
                if (fold_now && ($urandom_range(1) == 1) &&
                    (((b >= CHAR_UPPER_A) && (b <= CHAR_UPPER_Z)) ||
                     ((b >= CHAR_LOWER_A) && (b <= CHAR_LOWER_Z))))
                    b = b ^ CASE_OFFSET;
                word.insert(at + i, b);
            end
        end
        foreach (word[j])
            send_byte(word[j]);
        send_byte(rand_gap_byte());
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        sb.set_reg(idx, data);
    endtask

    task automatic load_rules(input logic [4:0] plen, input logic [4:0] rlen, input bit fold);
        logic [63:0] p_lo, p_hi, r_lo, r_hi, junk;
        int          k;
        for (k = 0; k < 8; k++)
        begin
            p_lo[8*k +: 8] = pat_text[k];
            p_hi[8*k +: 8] = pat_text[k + 8];
            r_lo[8*k +: 8] = rep_text[k];
            r_hi[8*k +: 8] = rep_text[k + 8];
        end
        junk = ($urandom_range(1) == 1) ? {$urandom, $urandom} : '0;
        write_reg(CFG_PATTERN_LOW, p_lo);
        write_reg(CFG_PATTERN_HIGH, p_hi);
        write_reg(CFG_PATTERN_LEN, {junk[63:5], plen});
        write_reg(CFG_REPLACE_LOW, r_lo);
        write_reg(CFG_REPLACE_HIGH, r_hi);
        write_reg(CFG_REPLACE_LEN, {junk[63:5], rlen});
        write_reg(CFG_CASE_IGNORE, {junk[63:1], fold});
        cfg_valid <= 1'b0;
        eff_plen = (plen > PATTERN_MAX_DEF) ? PATTERN_MAX_DEF : int'(plen);
        fold_now = fold;
        rule_sets++;
    endtask

    // block idle: all rewrites out and any silent search finished
    task automatic settle();
        text_valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    initial
    begin
        int hold_left;
        hold_left = 0;
        result_stall <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (result_valid && !result_stall)
                sb.check_beat(char_out, last);
            if (hold_req)
            begin
                hold_left = HOLD_CYCLES;
                hold_req = 1'b0;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                result_stall <= 1'b1;
            end
            else
                result_stall <= !calm && ($urandom_range(99) < 28);
        end
    end

    initial
    begin
        int quiet;
        quiet = 0;
        @(posedge rst_n);
        while (quiet < QUIET_LIMIT)
        begin
            @(posedge clk);
            if ((text_valid && !text_stall) || (result_valid && !result_stall) ||
                (cfg_valid && cfg_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("[%0t] no beat on any channel for %0d cycles", $time, QUIET_LIMIT);
        $display("CHECK FAILED");
        $finish;
    end

    initial
    begin
        logic [4:0] plen, rlen;
        bit         fold;
        int         goal, ph, k, pick, len;
        sb = new();
        calm = 1'b0;
        hold_req = 1'b0;
        fed_items = 0;
        rule_sets = 0;
        eff_plen = 0;
        fold_now = 1'b0;
        rst_n      <= 1'b0;
        text_valid <= 1'b0;
        char_in    <= '0;
        cfg_valid  <= 1'b0;
        cfg_index  <= '0;
        cfg_data   <= '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // rules out of reset: empty pattern, empty replacement
        send_text("aZ");
        send_byte(8'h00);
        send_byte(8'hff);
        settle();

        for (k = 0; k < 16; k++)
        begin
            pat_text[k] = 8'($urandom_range(255));
            rep_text[k] = 8'($urandom_range(255));
        end
        pat_text[0] = "A";
        pat_text[1] = "b";
        rep_text[0] = "0";
        rep_text[1] = "-";
        rep_text[2] = "9";
        write_reg(CFG_BAD_INDEX, '1);
        load_rules(5'd2, 5'd3, 1'b1);
        send_text("x0aB ");
        send_text("AB,");
        send_text("9-zZ");
        send_byte(8'h7f);
        send_text("A");
        send_byte(8'h80);
        settle();
        write_reg(CFG_CASE_IGNORE, '0);
        cfg_valid <= 1'b0;
        fold_now = 1'b0;
        send_text("aB Ab.");

        for (ph = 0; ph < PHASES; ph++)
        begin
            settle();
            for (k = 0; k < 16; k++)
            begin
                pat_text[k] = rand_word_byte();
                rep_text[k] = 8'($urandom_range(255));
            end
            fold = 1'($urandom_range(1));
            plen = 5'($urandom_range(16));
            rlen = 5'($urandom_range(16));
            calm = 1'b0;
            case (ph)
                0:
                begin
                    plen = 5'd1;
                    rlen = 5'd0;
                    fold = 1'b0;
                end
                1:
                begin
                    plen = 5'd0;
                    rlen = 5'd16;
                    fold = 1'b1;
                    calm = 1'b1;
                    for (k = 0; k < 16; k++)
                        rep_text[k] = 8'hff;
                end
                2:
                begin
                    plen = 5'd16;
                    rlen = 5'd3;
                    fold = 1'b0;
                end
                3:
                begin
                    plen = 5'd31;
                    rlen = 5'd31;
                    fold = 1'b1;
                    for (k = 0; k < 16; k++)
                        rep_text[k] = 8'h00;
                end
                4:
                begin
                    plen = 5'd2;
                    fold = 1'b0;
                    for (k = 0; k < 16; k++)
                        pat_text[k] = 8'($urandom_range(255));
                end
                5:
                begin
                    plen = 5'($urandom_range(17, 31));
                    rlen = 5'($urandom_range(17, 31));
                    write_reg(CFG_BAD_INDEX, {$urandom, $urandom});
                end
                6:
                begin
                    plen = 5'd3;
                    rlen = 5'd5;
                    fold = 1'b1;
                end
                default: ;
            endcase
            load_rules(plen, rlen, fold);
            // long receiver hold-off so the block backs up into the text side
            if (ph == 3)
                hold_req = 1'b1;
            goal = fed_items + PHASE_ITEMS;
            while (fed_items < goal)
            begin
                if ($urandom_range(99) < 80)
                begin
                    pick = $urandom_range(99);
                    if (pick < 85)
                        len = $urandom_range(1, 10);
                    else if (pick < 95)
                        len = $urandom_range(11, 31);
                    else
                        len = $urandom_range(32, 40);
                    send_word(len, $urandom_range(99) < 70);
                end
                else
                    send_byte(8'($urandom_range(255)));
            end
            send_byte(rand_gap_byte());
        end

        // a word left open at the end is never rewritten
        repeat (5) send_byte(rand_word_byte());
        settle();

        $display("fed %0d text bytes under %0d rule sets; %0d words closed, %0d rewritten",
                 fed_items, rule_sets, sb.words_closed, sb.words_rewritten);
        $display("%0d output beats compared, %0d mismatches, %0d rewrites outstanding",
                 sb.beats_seen, sb.errors, sb.pending());
        if ((sb.errors == 0) && (sb.pending() == 0))
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
